FILE: hdl/fpmg_pkg.sv
package fpmg_pkg;

   // field widths
   localparam int COL_W     = 10;
   localparam int COEF_W    = 21;
   localparam int ROW_W     = 3 * COEF_W;
   localparam int FOCAL_W   = 10;
   localparam int CENTER_W  = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = ROW_W;
   localparam int SRC_W     = 16;
   localparam int FIDX_W    = 10;

   localparam int FRAC_BITS_DEF = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INV_ROW0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_ROW1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_ROW2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_U   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_U    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_V  = 3'd6;

   // reset values: identity matrix and default lens geometry
   localparam logic [ROW_W-1:0]    INV_ROW0_RST = 63'h1000_0000_0000_0000;
   localparam logic [ROW_W-1:0]    INV_ROW1_RST = 63'h0000_0080_0000_0000;
   localparam logic [ROW_W-1:0]    INV_ROW2_RST = 63'h0000_0000_0004_0000;
   localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 10'd181;
   localparam logic [CENTER_W-1:0] FRONT_U_RST  = 11'd320;
   localparam logic [CENTER_W-1:0] BACK_U_RST   = 11'd958;
   localparam logic [CENTER_W-1:0] CENTER_V_RST = 11'd320;

   // datapath widths
   localparam int MAG_W        = 32;
   localparam int RAD_W        = 2 * MAG_W;
   localparam int ROOT_W       = MAG_W;
   localparam int CORDIC_ITERS = 20;
   localparam int ANG_W        = 27;
   localparam int THETA_W      = 25;
   localparam int QUO_W        = 21;
   localparam int CD_W         = 36;
   localparam logic [THETA_W-1:0] HALF_PI_ANG = 25'd26353589;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] row;
   } req_word_type;

   typedef struct packed {
      logic signed [SRC_W-1:0] src_u_int;
      logic signed [SRC_W-1:0] src_v_int;
      logic [FIDX_W-1:0]       frac_index;
      logic                    lens_select;
   } rsp_word_type;

   typedef struct packed {
      logic back;
      logic neg_u;
      logic neg_v;
      logic w_zero;
      logic rh_zero;
   } flag_type;

   typedef struct packed {
      logic [MAG_W-1:0] aw;
      logic [MAG_W-1:0] mx;
      logic [MAG_W-1:0] my;
      flag_type         flags;
   } sqrt_side_type;

   // atan(2^-i) in units of 2^-24 rad
   function automatic logic [ANG_W-1:0] atan_angle(input int idx);
      logic [ANG_W-1:0] a;
      case (idx)
         0:  a = 27'd13176795;
         1:  a = 27'd7778716;
         2:  a = 27'd4110060;
         3:  a = 27'd2086331;
         4:  a = 27'd1047214;
         5:  a = 27'd524117;
         6:  a = 27'd262123;
         7:  a = 27'd131069;
         8:  a = 27'd65536;
         9:  a = 27'd32768;
         10: a = 27'd16384;
         11: a = 27'd8192;
         12: a = 27'd4096;
         13: a = 27'd2048;
         14: a = 27'd1024;
         15: a = 27'd512;
         16: a = 27'd256;
         17: a = 27'd128;
         18: a = 27'd64;
         19: a = 27'd32;
         default: a = '0;
      endcase
      return a;
   endfunction

   // coefficient k of a packed matrix row, k = 0 at the top
   function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] rv,
                                                         input int k);
      return $signed(rv[ROW_W-1-COEF_W*k -: COEF_W]);
   endfunction

endpackage

FILE: hdl/fpmg_sqrt.sv
module fpmg_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [fpmg_pkg::RAD_W-1:0]    in_rad,
   input  fpmg_pkg::sqrt_side_type       in_side,
   output logic                          out_valid,
   output logic [fpmg_pkg::ROOT_W-1:0]   out_root,
   output fpmg_pkg::sqrt_side_type       out_side
);
   import fpmg_pkg::*;

   // one root bit per stage
   localparam int STAGES = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic                vld_ff  [STAGES];
   logic [RAD_W-1:0]    rad_ff  [STAGES];
   logic [REM_W-1:0]    rem_ff  [STAGES];
   logic [ROOT_W-1:0]   root_ff [STAGES];
   sqrt_side_type       side_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                prev_vld;
      logic [RAD_W-1:0]    prev_rad;
      logic [REM_W-1:0]    prev_rem;
      logic [ROOT_W-1:0]   prev_root;
      sqrt_side_type       prev_side;
      logic [REM_W+1:0]    rem_t;
      logic [REM_W+1:0]    trial;
      logic [REM_W-1:0]    rem_in;
      logic [ROOT_W-1:0]   root_in;
      logic [RAD_W-1:0]    rad_in;

      if (k == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rad  = in_rad;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[k-1];
         assign prev_rad  = rad_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      always_comb begin
         rem_t  = {prev_rem, prev_rad[RAD_W-1 -: 2]};
         trial  = {2'b00, prev_root, 2'b01};
         rad_in = {prev_rad[RAD_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = REM_W'(rem_t - trial);
            root_in = {prev_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[REM_W-1:0];
            root_in = {prev_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

FILE: hdl/fpmg_atan_div.sv
module fpmg_atan_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [fpmg_pkg::MAG_W-1:0]    in_aw,
   input  logic [fpmg_pkg::ROOT_W-1:0]   in_rh,
   input  logic [fpmg_pkg::MAG_W-1:0]    in_mag_u,
   input  logic [fpmg_pkg::MAG_W-1:0]    in_mag_v,
   input  fpmg_pkg::flag_type            in_flags,
   output logic                          out_valid,
   output logic [fpmg_pkg::THETA_W-1:0]  out_theta,
   output logic [fpmg_pkg::QUO_W-1:0]    out_quo_u,
   output logic [fpmg_pkg::QUO_W-1:0]    out_quo_v,
   output fpmg_pkg::flag_type            out_flags
);
   import fpmg_pkg::*;

   // one quotient bit per stage; cordic rotates in the first stages, last one clamps
   localparam int STAGES = QUO_W;
   localparam int REM_W  = ROOT_W + 1;

   logic                     vld_ff [STAGES];
   logic signed [CD_W-1:0]   x_ff   [STAGES];
   logic signed [CD_W-1:0]   y_ff   [STAGES];
   logic signed [ANG_W-1:0]  z_ff   [STAGES];
   logic [ROOT_W-1:0]        rh_ff  [STAGES];
   logic [REM_W-1:0]         ru_ff  [STAGES];
   logic [REM_W-1:0]         rv_ff  [STAGES];
   logic [QUO_W-1:0]         qu_ff  [STAGES];
   logic [QUO_W-1:0]         qv_ff  [STAGES];
   flag_type                 fl_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                     prev_vld;
      logic signed [CD_W-1:0]   prev_x;
      logic signed [CD_W-1:0]   prev_y;
      logic signed [ANG_W-1:0]  prev_z;
      logic [ROOT_W-1:0]        prev_rh;
      logic [REM_W-1:0]         prev_ru;
      logic [REM_W-1:0]         prev_rv;
      logic [QUO_W-1:0]         prev_qu;
      logic [QUO_W-1:0]         prev_qv;
      flag_type                 prev_fl;
      logic signed [CD_W-1:0]   x_in;
      logic signed [CD_W-1:0]   y_in;
      logic signed [ANG_W-1:0]  z_in;
      logic [REM_W-1:0]         su;
      logic [REM_W-1:0]         sv;
      logic                     ge_u;
      logic                     ge_v;

      if (k == 0) begin : g_first
         assign prev_vld = in_valid;
         assign prev_x   = $signed(CD_W'(in_aw));
         assign prev_y   = $signed(CD_W'(in_rh));
         assign prev_z   = '0;
         assign prev_rh  = in_rh;
         assign prev_ru  = REM_W'(in_mag_u);
         assign prev_rv  = REM_W'(in_mag_v);
         assign prev_qu  = '0;
         assign prev_qv  = '0;
         assign prev_fl  = in_flags;
         assign su       = prev_ru;
         assign sv       = prev_rv;
      end else begin : g_next
         assign prev_vld = vld_ff[k-1];
         assign prev_x   = x_ff[k-1];
         assign prev_y   = y_ff[k-1];
         assign prev_z   = z_ff[k-1];
         assign prev_rh  = rh_ff[k-1];
         assign prev_ru  = ru_ff[k-1];
         assign prev_rv  = rv_ff[k-1];
         assign prev_qu  = qu_ff[k-1];
         assign prev_qv  = qv_ff[k-1];
         assign prev_fl  = fl_ff[k-1];
         assign su       = {prev_ru[REM_W-2:0], 1'b0};
         assign sv       = {prev_rv[REM_W-2:0], 1'b0};
      end

      if (k < CORDIC_ITERS) begin : g_rot
         always_comb begin
            if (prev_y > 0) begin
               x_in = prev_x + (prev_y >>> k);
               y_in = prev_y - (prev_x >>> k);
               z_in = prev_z + $signed(atan_angle(k));
            end else begin
               x_in = prev_x - (prev_y >>> k);
               y_in = prev_y + (prev_x >>> k);
               z_in = prev_z - $signed(atan_angle(k));
            end
         end
      end else begin : g_clamp
         always_comb begin
            x_in = prev_x;
            y_in = prev_y;
            if (prev_z < 0) begin
               z_in = '0;
            end else if (prev_z > $signed(ANG_W'(HALF_PI_ANG))) begin
               z_in = $signed(ANG_W'(HALF_PI_ANG));
            end else begin
               z_in = prev_z;
            end
         end
      end

      assign ge_u = su >= REM_W'(prev_rh);
      assign ge_v = sv >= REM_W'(prev_rh);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]  <= x_in;
            y_ff[k]  <= y_in;
            z_ff[k]  <= z_in;
            rh_ff[k] <= prev_rh;
            ru_ff[k] <= ge_u ? REM_W'(su - REM_W'(prev_rh)) : su;
            rv_ff[k] <= ge_v ? REM_W'(sv - REM_W'(prev_rh)) : sv;
            qu_ff[k] <= {prev_qu[QUO_W-2:0], ge_u};
            qv_ff[k] <= {prev_qv[QUO_W-2:0], ge_v};
            fl_ff[k] <= prev_fl;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_theta = THETA_W'(z_ff[STAGES-1]);
   assign out_quo_u = qu_ff[STAGES-1];
   assign out_quo_v = qv_ff[STAGES-1];
   assign out_flags = fl_ff[STAGES-1];

endmodule

FILE: hdl/fisheye_perspective_map_generator_core.sv
// throughput: one word per cycle; a stalled rsp word freezes the whole pipeline
// depth is set by the 32-stage square root and the 21-stage atan / direction-cosine unit
// reset (synchronous, active high) clears all valid bits and loads the default
// identity matrix and lens geometry into the csr registers
module fisheye_perspective_map_generator_core #(
   parameter int FRAC_BITS = fpmg_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fpmg_pkg::req_word_type             req_word,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fpmg_pkg::rsp_word_type             rsp_word,
   // csr write port
   input  logic                               csr_wr_en,
   input  logic [fpmg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpmg_pkg::CSR_DAT_W-1:0]     csr_wr_data
);
   import fpmg_pkg::*;

   localparam int PROD_W  = COEF_W + COL_W + 1;
   localparam int H_W     = PROD_W + 2;
   localparam int FT_W    = FOCAL_W + THETA_W;
   localparam int P_W     = FT_W + QUO_W;
   localparam int WIDE_W  = P_W + 2;
   // offset scale: rounds focal * theta * cosine to 1/2^FRAC_BITS pixel
   localparam int SHIFT   = 44 - FRAC_BITS;
   localparam logic [WIDE_W-1:0] ROUND_ADD = WIDE_W'(64'd1 << (SHIFT - 1));
   // saturation limits of the position, in 1/2^FRAC_BITS pixel
   localparam logic signed [WIDE_W-1:0] POS_HI =
      WIDE_W'((64'sd1 <<< (SRC_W - 1 + FRAC_BITS)) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] POS_LO =
      WIDE_W'(-(64'sd1 <<< (SRC_W - 1 + FRAC_BITS)));

   // ---------------------------------------------------------------
   // csr registers
   // ---------------------------------------------------------------
   logic [ROW_W-1:0]    inv_row_ff [3];
   logic [FOCAL_W-1:0]  focal_ff;
   logic [CENTER_W-1:0] front_u_ff;
   logic [CENTER_W-1:0] back_u_ff;
   logic [CENTER_W-1:0] center_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_row_ff[0] <= INV_ROW0_RST;
         inv_row_ff[1] <= INV_ROW1_RST;
         inv_row_ff[2] <= INV_ROW2_RST;
         focal_ff      <= FOCAL_RST;
         front_u_ff    <= FRONT_U_RST;
         back_u_ff     <= BACK_U_RST;
         center_v_ff   <= CENTER_V_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_INV_ROW0: inv_row_ff[0] <= csr_wr_data;
            REG_INV_ROW1: inv_row_ff[1] <= csr_wr_data;
            REG_INV_ROW2: inv_row_ff[2] <= csr_wr_data;
            REG_FOCAL:    focal_ff      <= csr_wr_data[FOCAL_W-1:0];
            REG_FRONT_U:  front_u_ff    <= csr_wr_data[CENTER_W-1:0];
            REG_BACK_U:   back_u_ff     <= csr_wr_data[CENTER_W-1:0];
            REG_CENTER_V: center_v_ff   <= csr_wr_data[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // flow control: every stage moves together unless the output
   // word is held by the consumer
   // ---------------------------------------------------------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ---------------------------------------------------------------
   // stage 1: coefficient times column / row
   // ---------------------------------------------------------------
   logic                      v1_ff;
   logic signed [PROD_W-1:0]  pc_ff [3];
   logic signed [PROD_W-1:0]  pr_ff [3];
   logic signed [COEF_W-1:0]  cst_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            pc_ff[r]  <= coef_of(inv_row_ff[r], 0) * $signed({1'b0, req_word.col});
            pr_ff[r]  <= coef_of(inv_row_ff[r], 1) * $signed({1'b0, req_word.row});
            cst_ff[r] <= coef_of(inv_row_ff[r], 2);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 2: homogeneous x, y, w
   // ---------------------------------------------------------------
   logic                   v2_ff;
   logic signed [H_W-1:0]  h_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            h_ff[r] <= H_W'(pc_ff[r]) + H_W'(pr_ff[r]) + H_W'(cst_ff[r]);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 3: magnitudes, lens choice and signs of the offsets
   // ---------------------------------------------------------------
   logic          v3_ff;
   sqrt_side_type side3_in;
   sqrt_side_type side3_ff;
   logic [H_W-1:0] abs_h [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         abs_h[r] = h_ff[r][H_W-1] ? H_W'(-h_ff[r]) : H_W'(h_ff[r]);
      end
      side3_in.aw            = abs_h[2][MAG_W-1:0];
      side3_in.mx            = abs_h[0][MAG_W-1:0];
      side3_in.my            = abs_h[1][MAG_W-1:0];
      side3_in.flags.back    = h_ff[2][H_W-1];
      // the back lens mirrors u
      side3_in.flags.neg_u   = h_ff[0][H_W-1] ^ h_ff[2][H_W-1];
      side3_in.flags.neg_v   = h_ff[1][H_W-1];
      side3_in.flags.w_zero  = (h_ff[2] == '0);
      side3_in.flags.rh_zero = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side3_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: squares, stage 5: radicand
   // ---------------------------------------------------------------
   logic          v4_ff;
   logic          v5_ff;
   logic [RAD_W-1:0] sqx4_ff;
   logic [RAD_W-1:0] sqy4_ff;
   logic [RAD_W-1:0] rad5_ff;
   sqrt_side_type side4_ff;
   sqrt_side_type side5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx4_ff  <= side3_ff.mx * side3_ff.mx;
         sqy4_ff  <= side3_ff.my * side3_ff.my;
         side4_ff <= side3_ff;
         rad5_ff  <= sqx4_ff + sqy4_ff;
         side5_ff <= side4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------
   // radial distance rh = floor(sqrt(x^2 + y^2))
   // ---------------------------------------------------------------
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sqrt_side_type     sq_side;
   flag_type          ad_flags_in;

   fpmg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_rad    (rad5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      ad_flags_in         = sq_side.flags;
      ad_flags_in.rh_zero = (sq_root == '0);
   end

   // ---------------------------------------------------------------
   // theta = atan(rh / |w|) next to the two direction cosines
   // ---------------------------------------------------------------
   logic               ad_valid;
   logic [THETA_W-1:0] ad_theta;
   logic [QUO_W-1:0]   ad_quo_u;
   logic [QUO_W-1:0]   ad_quo_v;
   flag_type           ad_flags;

   fpmg_atan_div u_atan_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_aw     (sq_side.aw),
      .in_rh     (sq_root),
      .in_mag_u  (sq_side.mx),
      .in_mag_v  (sq_side.my),
      .in_flags  (ad_flags_in),
      .out_valid (ad_valid),
      .out_theta (ad_theta),
      .out_quo_u (ad_quo_u),
      .out_quo_v (ad_quo_v),
      .out_flags (ad_flags)
   );

   // ---------------------------------------------------------------
   // offset magnitude: focal * theta, then times each cosine
   // ---------------------------------------------------------------
   logic              vm1_ff;
   logic              vm2_ff;
   logic [FT_W-1:0]   ft_ff;
   logic [QUO_W-1:0]  cu_ff;
   logic [QUO_W-1:0]  cv_ff;
   flag_type          flm1_ff;
   logic [P_W-1:0]    pu_ff;
   logic [P_W-1:0]    pv_ff;
   flag_type          flm2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ft_ff   <= FT_W'(focal_ff) * FT_W'(ad_theta);
         cu_ff   <= ad_quo_u;
         cv_ff   <= ad_quo_v;
         flm1_ff <= ad_flags;
         pu_ff   <= P_W'(ft_ff) * P_W'(cu_ff);
         pv_ff   <= P_W'(ft_ff) * P_W'(cv_ff);
         flm2_ff <= flm1_ff;
      end
   end

   // ---------------------------------------------------------------
   // output stage: round, apply sign, add lens center, saturate
   // ---------------------------------------------------------------
   function automatic logic signed [WIDE_W-1:0] place_axis(
      input logic [P_W-1:0]      p,
      input logic                neg,
      input logic                zero,
      input logic [CENTER_W-1:0] center
   );
      logic [WIDE_W-1:0]        rnd;
      logic signed [WIDE_W-1:0] off;
      logic signed [WIDE_W-1:0] pos;
      rnd = (WIDE_W'(p) + ROUND_ADD) >> SHIFT;
      if (zero) begin
         rnd = '0;
      end
      off = neg ? -$signed(rnd) : $signed(rnd);
      pos = ($signed(WIDE_W'(center)) <<< FRAC_BITS) + off;
      if (pos < POS_LO) begin
         pos = POS_LO;
      end else if (pos > POS_HI) begin
         pos = POS_HI;
      end
      return pos;
   endfunction

   logic signed [WIDE_W-1:0]    pos_u;
   logic signed [WIDE_W-1:0]    pos_v;
   logic [2*FRAC_BITS+FIDX_W-1:0] fidx_ext;
   rsp_word_type                rsp_word_in;
   rsp_word_type                rsp_word_ff;

   always_comb begin
      pos_u = place_axis(pu_ff, flm2_ff.neg_u, flm2_ff.rh_zero,
                         flm2_ff.back ? back_u_ff : front_u_ff);
      pos_v = place_axis(pv_ff, flm2_ff.neg_v, flm2_ff.rh_zero, center_v_ff);
      // v fraction above u fraction, cut to the index width
      fidx_ext = {{FIDX_W{1'b0}}, pos_v[FRAC_BITS-1:0], pos_u[FRAC_BITS-1:0]};
      if (flm2_ff.w_zero) begin
         // point at infinity: pinned to the most negative corner
         rsp_word_in.src_u_int   = {1'b1, {(SRC_W-1){1'b0}}};
         rsp_word_in.src_v_int   = {1'b1, {(SRC_W-1){1'b0}}};
         rsp_word_in.frac_index  = '0;
         rsp_word_in.lens_select = 1'b1;
      end else begin
         rsp_word_in.src_u_int   = pos_u[FRAC_BITS+SRC_W-1:FRAC_BITS];
         rsp_word_in.src_v_int   = pos_v[FRAC_BITS+SRC_W-1:FRAC_BITS];
         rsp_word_in.frac_index  = fidx_ext[FIDX_W-1:0];
         rsp_word_in.lens_select = flm2_ff.back;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm1_ff       <= 1'b0;
         vm2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vm1_ff       <= ad_valid;
         vm2_ff       <= vm1_ff;
         rsp_valid_ff <= vm2_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // an accepted word shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word missing in first stage");

   // a frozen pipeline keeps its late valid bits
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(vm2_ff) && $stable(vm1_ff) && $stable(v5_ff)))
      else $error("pipeline moved while frozen");

   // a zero w word leaves as the pinned back-lens result
   a_wzero: assert property (@(posedge clock) disable iff (reset)
      (en && vm2_ff && flm2_ff.w_zero) |=>
      (rsp_valid && rsp_word.lens_select && rsp_word.frac_index == '0))
      else $error("zero w result malformed");

   // a word with a positive w always leaves as a front lens word
   a_front: assert property (@(posedge clock) disable iff (reset)
      (en && vm2_ff && !flm2_ff.back && !flm2_ff.w_zero) |=> !rsp_word.lens_select)
      else $error("front lens flag lost");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import fpmg_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int DRAIN_WAIT = 80;        // beyond the pipeline depth
   localparam int CYCLE_CAP  = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here
   localparam longint ATAN_STEP [CORDIC_ITERS] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wr_data;
   req_word_type req_word;
   rsp_word_type rsp_word;

   // shadow copy of the csr file
   bit [ROW_W-1:0]    mat_row [3];
   bit [FOCAL_W-1:0]  focal;
   bit [CENTER_W-1:0] front_u, back_u, ctr_v;

   rsp_word_type map_queue [$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   fisheye_perspective_map_generator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data));

   initial begin
      forever #5 clock = ~clock;
   end

   // signed Q3.18 coefficient k of a matrix row
   function automatic longint coef_val(bit [ROW_W-1:0] rv, int k);
      bit signed [COEF_W-1:0] f;
      f = rv[ROW_W-1-COEF_W*k -: COEF_W];
      return longint'(f);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // vectoring cordic on (|w|, r): angle in 2^-24 rad
   function automatic longint view_angle(longint x, longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_STEP[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_STEP[i];
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (z > longint'(HALF_PI_ANG)) z = longint'(HALF_PI_ANG);
      return z;
   endfunction

   // focal * theta * direction cosine, rounded to 1/32 pixel
   function automatic longint lens_offset(bit [63:0] theta, bit [63:0] mag, bit [63:0] rh,
                                          bit neg);
      bit [63:0] c, p, q;
      c = (mag << 20) / rh;
      p = 64'(focal) * theta * c;
      q = (p + (64'd1 << (43 - FRAC))) >> (44 - FRAC);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_pos(bit [CENTER_W-1:0] center, longint off);
      longint v;
      v = longint'(center) * (1 << FRAC) + off;
      if (v < -32768 * (1 << FRAC)) v = -32768 * (1 << FRAC);
      if (v > 32768 * (1 << FRAC) - 1) v = 32768 * (1 << FRAC) - 1;
      return v;
   endfunction

   function automatic rsp_word_type source_map(req_word_type w);
      rsp_word_type o;
      longint h [3];
      longint du, dv, iu, iv;
      bit [63:0] mx, my, aw, rh, theta;
      bit back;
      for (int r = 0; r < 3; r++)
         h[r] = coef_val(mat_row[r], 0) * longint'(w.col)
              + coef_val(mat_row[r], 1) * longint'(w.row) + coef_val(mat_row[r], 2);
      if (h[2] == 0) begin
         o.src_u_int = 16'h8000;
         o.src_v_int = 16'h8000;
         o.frac_index = '0;
         o.lens_select = 1'b1;
         return o;
      end
      back = h[2] < 0;
      aw = back ? -h[2] : h[2];
      mx = h[0] < 0 ? -h[0] : h[0];
      my = h[1] < 0 ? -h[1] : h[1];
      rh = int_sqrt(mx * mx + my * my);
      du = 0;
      dv = 0;
      if (rh != 0) begin
         theta = view_angle(longint'(aw), longint'(rh));
         du = lens_offset(theta, mx, rh, (h[0] < 0) != back);
         dv = lens_offset(theta, my, rh, h[1] < 0);
      end
      iu = clamp_pos(back ? back_u : front_u, du);
      iv = clamp_pos(ctr_v, dv);
      o.src_u_int = 16'(iu >>> FRAC);
      o.src_v_int = 16'(iv >>> FRAC);
      o.frac_index = {iv[FRAC-1:0], iu[FRAC-1:0]};
      o.lens_select = back;
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // random rsp backpressure
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // expected map word for each accepted req word
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) map_queue.push_back(source_map(req_word));
   end

   // compare each accepted rsp word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (map_queue.size() == 0) begin
            report("unexpected word", 64'(rsp_word), 64'd0);
         end else begin
            e = map_queue.pop_front();
            if (rsp_word.src_u_int !== e.src_u_int)
               report("src_u_int", 64'(rsp_word.src_u_int), 64'(e.src_u_int));
            if (rsp_word.src_v_int !== e.src_v_int)
               report("src_v_int", 64'(rsp_word.src_v_int), 64'(e.src_v_int));
            if (rsp_word.frac_index !== e.frac_index)
               report("frac_index", 64'(rsp_word.frac_index), 64'(e.frac_index));
            if (rsp_word.lens_select !== e.lens_select)
               report("lens_select", 64'(rsp_word.lens_select), 64'(e.lens_select));
         end
      end
   end

   task automatic send_word(bit [COL_W-1:0] c, bit [COL_W-1:0] r);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{col: c, row: r};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // lower valid and let everything drain out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (map_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // csr writes only land on an empty pipeline
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, bit [CSR_DAT_W-1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (map_queue.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_INV_ROW0: mat_row[0] = val;
         REG_INV_ROW1: mat_row[1] = val;
         REG_INV_ROW2: mat_row[2] = val;
         REG_FOCAL:    focal = val[FOCAL_W-1:0];
         REG_FRONT_U:  front_u = val[CENTER_W-1:0];
         REG_BACK_U:   back_u = val[CENTER_W-1:0];
         REG_CENTER_V: ctr_v = val[CENTER_W-1:0];
         default: ;   // unused index is ignored
      endcase
   endtask

   function automatic bit [ROW_W-1:0] pack_row(int k0, int k1, int k2);
      bit [COEF_W-1:0] a, b, c;
      a = COEF_W'(k0);
      b = COEF_W'(k1);
      c = COEF_W'(k2);
      return {a, b, c};
   endfunction

   // mostly sensible coefficients, sometimes the full range
   function automatic int rand_coef();
      case ($urandom_range(3))
         0: return $signed(21'($urandom));
         1: return $urandom_range(1 << 12) - (1 << 11);
         2: return $urandom_range(1 << 19) - (1 << 18);
         default: return -($urandom_range(1 << 20));
      endcase
   endfunction

   task automatic rand_geometry();
      csr_write(REG_INV_ROW0, pack_row(rand_coef(), rand_coef(), rand_coef()));
      csr_write(REG_INV_ROW1, pack_row(rand_coef(), rand_coef(), rand_coef()));
      csr_write(REG_INV_ROW2, pack_row(rand_coef(), rand_coef(), rand_coef()));
      csr_write(REG_FOCAL, CSR_DAT_W'({$urandom, $urandom}));
      csr_write(REG_FRONT_U, CSR_DAT_W'($urandom));
      csr_write(REG_BACK_U, CSR_DAT_W'($urandom));
      csr_write(REG_CENTER_V, CSR_DAT_W'($urandom));
   endtask

   // reset geometry: raster corners and the middle
   task automatic test_defaults();
      send_word(0, 0);
      send_word(1023, 1023);
      send_word(1023, 0);
      send_word(0, 1023);
      send_word(512, 384);
      send_word(10'h2AA, 10'h155);
      drain();
   endtask

   // w zero gives the saturated marker word
   task automatic test_zero_w();
      csr_write(REG_INV_ROW2, pack_row(0, 0, 0));
      send_word(100, 200);
      send_word(1023, 767);
      drain();
   endtask

   // xh = yh = 0: offsets vanish, both lenses
   task automatic test_on_axis();
      csr_write(REG_INV_ROW0, pack_row(0, 0, 0));
      csr_write(REG_INV_ROW1, pack_row(0, 0, 0));
      csr_write(REG_INV_ROW2, pack_row(0, 0, 1 << 18));
      send_word(5, 7);
      csr_write(REG_INV_ROW2, pack_row(0, 0, -(1 << 18)));
      send_word(5, 7);
      drain();
   endtask

   // negative w selects the back lens, plus extreme csr values
   task automatic test_back_and_extremes();
      csr_write(REG_INV_ROW0, pack_row(1 << 18, 0, -(512 << 18)));
      csr_write(REG_INV_ROW1, pack_row(0, 1 << 18, -(384 << 18)));
      csr_write(REG_INV_ROW2, pack_row(0, 0, -(300 << 10)));
      csr_write(REG_UNUSED, '1);
      send_word(0, 0);
      send_word(1023, 767);
      csr_write(REG_FOCAL, '1);
      csr_write(REG_FRONT_U, '1);
      csr_write(REG_BACK_U, '1);
      csr_write(REG_CENTER_V, '1);
      send_word(1023, 1023);
      send_word(0, 0);
      csr_write(REG_FOCAL, '0);
      csr_write(REG_FRONT_U, '0);
      csr_write(REG_BACK_U, '0);
      csr_write(REG_CENTER_V, '0);
      send_word(1023, 0);
      csr_write(REG_INV_ROW0, {1'b1, 20'h0, 1'b1, 20'h0, 1'b1, 20'h0});
      csr_write(REG_INV_ROW1, {3{21'h0FFFFF}});
      csr_write(REG_INV_ROW2, {1'b1, 20'h0, 1'b1, 20'h0, 1'b1, 20'h0});
      send_word(1023, 1023);
      send_word(0, 0);
      drain();
   endtask

   // random words over random geometry, in the four idling phases
   task automatic test_random();
      int idle_tab [4] = '{0, 45, 0, 38};
      int stall_tab [4] = '{0, 0, 45, 38};
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_tab[ph];
         stall_pct = stall_tab[ph];
         for (int g = 0; g < 5; g++) begin
            rand_geometry();
            for (int n = 0; n < 40; n++) begin
               if (n == 20 && g == 2) begin
                  // sender holds off until all words are back
                  req_valid <= 1'b0;
                  @(posedge clock);
                  while (map_queue.size() != 0) @(posedge clock);
               end
               send_word(COL_W'($urandom), COL_W'($urandom));
            end
            drain();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      mat_row[0] = INV_ROW0_RST;
      mat_row[1] = INV_ROW1_RST;
      mat_row[2] = INV_ROW2_RST;
      focal = FOCAL_RST;
      front_u = FRONT_U_RST;
      back_u = BACK_U_RST;
      ctr_v = CENTER_V_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_zero_w();
      test_on_axis();
      test_back_and_extremes();
      test_random();
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule
